/* rtl/ctm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctm_pkg
// Shared types, sizes, register codes and helpers for the color threshold
// mask block with square closing.
// ----------------------------------------------------------------------------
package ctm_pkg;

	// sizes
	localparam int MAX_WIDTH    = 2048;
	localparam int KSIZE        = 5;
	localparam int RADIUS       = KSIZE / 2;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WID_W        = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W        = $clog2(HEIGHT_LIMIT + 4 * KSIZE + 1);
	localparam int POS_W        = (WID_W > ROW_W) ? WID_W : ROW_W;
	localparam int POS_X        = POS_W + 1;
	localparam int LEAD_W       = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

	// configuration port
	localparam int CFG_W = 13;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_BLUE_LOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_BLUE_HIGH    = 3'd1;
	localparam logic [IDX_W-1:0] REG_GREEN_LOW    = 3'd2;
	localparam logic [IDX_W-1:0] REG_GREEN_HIGH   = 3'd3;
	localparam logic [IDX_W-1:0] REG_RED_LOW      = 3'd4;
	localparam logic [IDX_W-1:0] REG_RED_HIGH     = 3'd5;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd6;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd7;

	localparam logic [7:0]  RST_BLUE_LOW     = 8'd0;
	localparam logic [7:0]  RST_BLUE_HIGH    = 8'd67;
	localparam logic [7:0]  RST_GREEN_LOW    = 8'd28;
	localparam logic [7:0]  RST_GREEN_HIGH   = 8'd125;
	localparam logic [7:0]  RST_RED_LOW      = 8'd105;
	localparam logic [7:0]  RST_RED_HIGH     = 8'd220;
	localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
	localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;

	// channel payloads
	typedef struct packed {
		logic       command;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} ctm_in_t;

	typedef struct packed {
		logic mask;
		logic frame_end;
	} ctm_out_t;

	// col: column of the stream item entering the line buffers
	// row_ok/col_ok: in-frame flags of the window rows/columns around the center
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [KSIZE-1:0] row_ok;
		logic [KSIZE-1:0] col_ok;
	} ctm_pos_t;

	// sideband carried through a window stage
	typedef struct packed {
		ctm_pos_t pos;
		logic     go;
		logic     emit;
		logic     last;
	} ctm_tag_t;

	typedef struct packed {
		logic     pix;
		ctm_pos_t pos;
		ctm_tag_t tag;
	} ctm_stage_in_t;

	typedef struct packed {
		logic     pix;
		ctm_tag_t tag;
	} ctm_stage_out_t;

	// bit i set when pos + (i - RADIUS) lies in [0, lim)
	function automatic logic [KSIZE-1:0] span_mask(input logic [POS_W-1:0] pos,
		input logic [POS_W-1:0] lim);
		logic [KSIZE-1:0] m;
		logic [POS_W:0]   hi;
		logic [POS_W:0]   cap;
		m = '0;
		for (int i = 0; i < KSIZE; i++) begin
			hi   = POS_X'(pos) + POS_X'((i >= RADIUS) ? (i - RADIUS) : 0);
			cap  = POS_X'(lim) + POS_X'((i < RADIUS) ? (RADIUS - i) : 0);
			m[i] = (pos >= POS_W'((i < RADIUS) ? (RADIUS - i) : 0)) && (hi < cap);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

/* rtl/ctm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctm_front
// Config registers, frame latch, stream position counters and the color
// threshold; registers one stage item per accepted pixel.
// ----------------------------------------------------------------------------
module ctm_front import ctm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              run,
	input  wire logic              pix_accept,
	input  wire ctm_in_t           pix_item,
	input  wire logic              cfg_write,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	output logic                   valid_s1,
	output ctm_stage_in_t          data_s1
);

	logic [7:0]  blue_low_q, blue_high_q, green_low_q, green_high_q, red_low_q, red_high_q;
	logic [11:0] frame_width_q;
	logic [12:0] frame_height_q;

	logic              active_q;
	logic [WID_W-1:0]  cur_w_q;
	logic [ROW_W-1:0]  cur_h_q;
	logic [COL_W-1:0]  ic_q, pc_q, mc_q;
	logic [ROW_W-1:0]  ir_q, pr_q, mr_q;
	logic [LEAD_W-1:0] lead1_q, lead2_q;

	logic [WID_W-1:0]  w_new, w_e;
	logic [ROW_W-1:0]  h_new, h_e;
	logic [LEAD_W-1:0] lag, lead1_e, lead2_e;
	logic [COL_W-1:0]  ic_e, pc_e, mc_e;
	logic [ROW_W-1:0]  ir_e, pr_e, mr_e;
	logic              pv, mv, last, hit;
	logic              ic_wrap, pc_wrap, mc_wrap;
	ctm_stage_in_t     item_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blue_low_q     <= RST_BLUE_LOW;
			blue_high_q    <= RST_BLUE_HIGH;
			green_low_q    <= RST_GREEN_LOW;
			green_high_q   <= RST_GREEN_HIGH;
			red_low_q      <= RST_RED_LOW;
			red_high_q     <= RST_RED_HIGH;
			frame_width_q  <= RST_FRAME_WIDTH;
			frame_height_q <= RST_FRAME_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_BLUE_LOW:     blue_low_q     <= cfg_data[7:0];
				REG_BLUE_HIGH:    blue_high_q    <= cfg_data[7:0];
				REG_GREEN_LOW:    green_low_q    <= cfg_data[7:0];
				REG_GREEN_HIGH:   green_high_q   <= cfg_data[7:0];
				REG_RED_LOW:      red_low_q      <= cfg_data[7:0];
				REG_RED_HIGH:     red_high_q     <= cfg_data[7:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[11:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// clamp the frame size; it is taken over at the first item of a frame
		if (frame_width_q == '0)
			w_new = WID_W'(1);
		else if (16'(frame_width_q) > 16'(MAX_WIDTH))
			w_new = WID_W'(MAX_WIDTH);
		else
			w_new = WID_W'(frame_width_q);
		if (frame_height_q == '0)
			h_new = ROW_W'(1);
		else if (16'(frame_height_q) > 16'(HEIGHT_LIMIT))
			h_new = ROW_W'(HEIGHT_LIMIT);
		else
			h_new = ROW_W'(frame_height_q);

		w_e     = active_q ? cur_w_q : w_new;
		h_e     = active_q ? cur_h_q : h_new;
		lag     = LEAD_W'(RADIUS) * LEAD_W'(w_e) + LEAD_W'(RADIUS);
		lead1_e = active_q ? lead1_q : lag;
		lead2_e = active_q ? lead2_q : lag;
		ic_e    = active_q ? ic_q : '0;
		ir_e    = active_q ? ir_q : '0;
		pc_e    = active_q ? pc_q : '0;
		pr_e    = active_q ? pr_q : '0;
		mc_e    = active_q ? mc_q : '0;
		mr_e    = active_q ? mr_q : '0;

		// dilation center valid after one lag, erosion center after two
		pv   = (lead1_e == '0);
		mv   = pv && (lead2_e == '0);
		last = mv && (mr_e == h_e - ROW_W'(1)) && (WID_W'(mc_e) == w_e - WID_W'(1));

		ic_wrap = (WID_W'(ic_e) == w_e - WID_W'(1));
		pc_wrap = (WID_W'(pc_e) == w_e - WID_W'(1));
		mc_wrap = (WID_W'(mc_e) == w_e - WID_W'(1));

		// flush items and anything past the last row count as out of range
		hit = !pix_item.command && (ir_e < h_e) &&
			(pix_item.blue >= blue_low_q) && (pix_item.blue <= blue_high_q) &&
			(pix_item.green >= green_low_q) && (pix_item.green <= green_high_q) &&
			(pix_item.red >= red_low_q) && (pix_item.red <= red_high_q);

		item_d.pix            = hit;
		item_d.pos.col        = ic_e;
		item_d.pos.row_ok     = span_mask(POS_W'(pr_e), POS_W'(h_e));
		item_d.pos.col_ok     = span_mask(POS_W'(pc_e), POS_W'(w_e));
		item_d.tag.pos.col    = pc_e;
		item_d.tag.pos.row_ok = span_mask(POS_W'(mr_e), POS_W'(h_e));
		item_d.tag.pos.col_ok = span_mask(POS_W'(mc_e), POS_W'(w_e));
		item_d.tag.go         = pv;
		item_d.tag.emit       = mv;
		item_d.tag.last       = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_w_q  <= WID_W'(1);
			cur_h_q  <= ROW_W'(1);
			ic_q     <= '0;
			ir_q     <= '0;
			pc_q     <= '0;
			pr_q     <= '0;
			mc_q     <= '0;
			mr_q     <= '0;
			lead1_q  <= '0;
			lead2_q  <= '0;
			valid_s1 <= 1'b0;
		end else if (run) begin
			valid_s1 <= pix_accept;
			if (pix_accept) begin
				active_q <= !last;
				cur_w_q  <= w_e;
				cur_h_q  <= h_e;
				ic_q     <= ic_wrap ? '0 : ic_e + COL_W'(1);
				ir_q     <= ic_wrap ? ir_e + ROW_W'(1) : ir_e;
				if (pv) begin
					pc_q <= pc_wrap ? '0 : pc_e + COL_W'(1);
					pr_q <= pc_wrap ? pr_e + ROW_W'(1) : pr_e;
				end else begin
					pc_q <= pc_e;
					pr_q <= pr_e;
				end
				if (mv) begin
					mc_q <= mc_wrap ? '0 : mc_e + COL_W'(1);
					mr_q <= mc_wrap ? mr_e + ROW_W'(1) : mr_e;
				end else begin
					mc_q <= mc_e;
					mr_q <= mr_e;
				end
				lead1_q <= pv ? lead1_e : lead1_e - LEAD_W'(1);
				lead2_q <= (pv && !mv) ? lead2_e - LEAD_W'(1) : lead2_e;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (run && pix_accept)
			data_s1 <= item_d;
	end

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(run && pix_accept && last) |=> !active_q)
		else $error("frame stays open after its last mask pixel");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (WID_W'(ic_q) < cur_w_q))
		else $error("input column beyond frame width");

endmodule
`default_nettype wire

/* rtl/ctm_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctm_stage
// One square dilation stage: line buffer history, sliding window, OR of the
// in-frame window bits. Erosion uses it on inverted data.
// ----------------------------------------------------------------------------
module ctm_stage import ctm_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           run,
	input  wire logic           in_valid,
	input  wire ctm_stage_in_t  in_data,
	output logic                out_valid,
	output ctm_stage_out_t      out_data
);

	// per column: the last KSIZE-1 rows, newest in the top bit
	logic [KSIZE-2:0] hist_mem [MAX_WIDTH];

	logic             valid_s2, valid_s3, valid_s4;
	ctm_stage_in_t    item_s2;
	logic [KSIZE-2:0] rd_s2, byp_s2;
	logic             fwd_s2;
	logic [KSIZE-1:0] row_ok_s3, col_ok_s3;
	ctm_tag_t         tag_s3;
	ctm_stage_out_t   data_s4;

	// win_q[j]: column offset j - RADIUS, bit i: row offset i - RADIUS
	logic [KSIZE-1:0] win_q [KSIZE];

	logic [KSIZE-2:0] old_s2, wr_s2;
	logic [KSIZE-1:0] vec_s2;
	logic             hit_s3;

	always_comb begin
		old_s2 = fwd_s2 ? byp_s2 : rd_s2;
		vec_s2 = {item_s2.pix, old_s2};
		wr_s2  = vec_s2[KSIZE-1:1];
	end

	always_ff @(posedge clk) begin
		if (run) begin
			rd_s2 <= hist_mem[in_data.pos.col];
			if (valid_s2)
				hist_mem[item_s2.pos.col] <= wr_s2;
		end
	end

	// back-to-back items on one column (one-pixel rows) bypass the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			fwd_s2   <= 1'b0;
			for (int j = 0; j < KSIZE; j++)
				win_q[j] <= '0;
		end else if (run) begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			fwd_s2   <= valid_s2 && in_valid && (in_data.pos.col == item_s2.pos.col);
			if (valid_s2) begin
				for (int j = 0; j < KSIZE - 1; j++)
					win_q[j] <= win_q[j+1];
				win_q[KSIZE-1] <= vec_s2;
			end
		end
	end

	always_comb begin
		hit_s3 = 1'b0;
		for (int j = 0; j < KSIZE; j++)
			for (int i = 0; i < KSIZE; i++)
				hit_s3 = hit_s3 | (win_q[j][i] & row_ok_s3[i] & col_ok_s3[j]);
	end

	always_ff @(posedge clk) begin
		if (run) begin
			item_s2      <= in_data;
			byp_s2       <= wr_s2;
			row_ok_s3    <= item_s2.pos.row_ok;
			col_ok_s3    <= item_s2.pos.col_ok;
			tag_s3       <= item_s2.tag;
			data_s4.pix  <= hit_s3;
			data_s4.tag  <= tag_s3;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s2 |-> valid_s2)
		else $error("line buffer bypass without an item behind it");

endmodule
`default_nettype wire

/* rtl/ctm_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctm_out
// Output register with a one-item skid; freezes the pipeline only when the
// skid is occupied.
// ----------------------------------------------------------------------------
module ctm_out import ctm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     res_valid,
	input  wire ctm_out_t res_item,
	output logic          run,
	output logic          mask_valid,
	input  wire logic     mask_stall,
	output ctm_out_t      mask_item
);

	logic     mask_valid_q, skid_valid_q;
	ctm_out_t mask_item_q, skid_item_q;
	logic     take;

	assign take = mask_valid_q && !mask_stall;
	assign run  = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			priority if (run && res_valid) begin
				if (!mask_valid_q || take)
					mask_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end else if (take) begin
				if (skid_valid_q)
					skid_valid_q <= 1'b0;
				else
					mask_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (run && res_valid) begin
			if (!mask_valid_q || take)
				mask_item_q <= res_item;
			else
				skid_item_q <= res_item;
		end else if (take && skid_valid_q) begin
			mask_item_q <= skid_item_q;
		end
	end

	assign mask_valid = mask_valid_q;
	assign mask_item  = mask_item_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> mask_valid_q)
		else $error("skid holds an item while the output register is empty");

endmodule
`default_nettype wire

/* rtl/color_threshold_mask_closing.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// color_threshold_mask_closing
// BGR color threshold followed by a 5x5 square closing of the mask.
// ----------------------------------------------------------------------------
// Usage:
//  - pix channel (pix_valid / pix_stall / pix_item) takes BGR pixels in raster
//    order; command=1 marks a flush item. After the last pixel, send flush
//    items until the result with frame_end=1 comes out.
//  - mask channel (mask_valid / mask_stall / mask_item) gives one closed mask
//    bit per item once the lag of 2*(2*W+2) items is filled (W = frame width),
//    i.e. four rows plus four pixels behind the input.
//  - Throughput: one item per clock while the skid is not full. A result
//    passes the front register (loaded at the accepting edge) and the two
//    window stages into the output register, and leaves at the next edge
//    when the receiver does not stall.
//  - Config (cfg_write / cfg_index / cfg_data) only while idle; frame size is
//    taken over at the first item of each frame.
//  - Reset: registers return to their defaults, counters clear. Line buffers
//    are not cleared; rows outside the frame are masked off instead.
//  - Receiver stall: the output register plus a one-item skid absorb it; once
//    the skid fills, pix_stall rises and the whole pipeline holds.
// ----------------------------------------------------------------------------
module color_threshold_mask_closing import ctm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pix_valid,
	output logic                  pix_stall,
	input  wire ctm_in_t          pix_item,
	output logic                  mask_valid,
	input  wire logic             mask_stall,
	output ctm_out_t              mask_item,
	input  wire logic             cfg_write,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	logic           run;
	logic           pix_accept;
	logic           fe_valid;
	ctm_stage_in_t  fe_data;
	logic           dil_valid, ero_in_valid, ero_valid;
	ctm_stage_out_t dil_data, ero_data;
	ctm_stage_in_t  ero_in;
	logic           res_valid;
	ctm_out_t       res_item;

	// the pipeline only holds while the skid slot is full
	assign pix_stall  = !run;
	assign pix_accept = pix_valid && !pix_stall;

	// thresholds, frame counters, window masks
	ctm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.run        (run),
		.pix_accept (pix_accept),
		.pix_item   (pix_item),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.valid_s1   (fe_valid),
		.data_s1    (fe_data)
	);

	// dilation: outside pixels count as 0
	ctm_stage u_dilate (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.in_valid  (fe_valid),
		.in_data   (fe_data),
		.out_valid (dil_valid),
		.out_data  (dil_data)
	);

	// erosion as dilation of the complement; outside then counts as 1
	always_comb begin
		ero_in          = '0;
		ero_in.pix      = ~dil_data.pix;
		ero_in.pos      = dil_data.tag.pos;
		ero_in.tag.emit = dil_data.tag.emit;
		ero_in.tag.last = dil_data.tag.last;
	end

	// only items with a dilation center enter the erosion stream
	assign ero_in_valid = dil_valid && dil_data.tag.go;

	ctm_stage u_erode (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.in_valid  (ero_in_valid),
		.in_data   (ero_in),
		.out_valid (ero_valid),
		.out_data  (ero_data)
	);

	assign res_valid          = ero_valid && ero_data.tag.emit;
	assign res_item.mask      = ~ero_data.pix;
	assign res_item.frame_end = ero_data.tag.last;

	ctm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res_item   (res_item),
		.run        (run),
		.mask_valid (mask_valid),
		.mask_stall (mask_stall),
		.mask_item  (mask_item)
	);

endmodule
`default_nettype wire
